/* sv/sltt_pkg.sv */
// Shared types and constants for the subscription lease timer table.
`default_nettype none
package sltt_pkg;

   // Request kinds as they arrive on the input channel
   localparam logic [1:0] KIND_ADD  = 2'd0;
   localparam logic [1:0] KIND_STOP = 2'd1;
   localparam logic [1:0] KIND_POLL = 2'd2;

   // Result codes
   localparam logic [2:0] EV_REFRESHED = 3'd0;
   localparam logic [2:0] EV_INSERTED  = 3'd1;
   localparam logic [2:0] EV_FULL      = 3'd2;
   localparam logic [2:0] EV_STOPPED   = 3'd3;
   localparam logic [2:0] EV_SELF      = 3'd4;
   localparam logic [2:0] EV_DUE       = 3'd5;
   localparam logic [2:0] EV_POLL_DONE = 3'd6;

   // Time scaling
   localparam logic [19:0] US_PER_S  = 20'd1000000;
   localparam logic [9:0]  US_PER_MS = 10'd1000;

   // Width of the table fill count seen by status logic (counts up to 63)
   localparam int CNT_W = 6;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] now_us;
      logic [31:0] peer_addr;
      logic [31:0] sub_id;
      logic [15:0] duration_s;
      logic [15:0] period_ms;
      logic [15:0] req_action;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [31:0] out_peer;
      logic [31:0] out_sub_id;
      logic [15:0] out_action;
      logic        last;
   } rsp_type;

   // Classified request held in the queue between front and back
   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] now_us;
      logic [31:0] peer;
      logic [31:0] id;
      logic [15:0] action;
      logic [15:0] period_ms;
      logic [35:0] dur_us;
      logic [25:0] per_us;
   } item_type;

   typedef struct packed {
      logic [31:0] peer;
      logic [31:0] id;
      logic [15:0] action;
      logic [15:0] period_ms;
      logic [63:0] end_us;
      logic [63:0] due_us;
   } lease_type;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             idle;
   } status_type;

endpackage
`default_nettype wire

/* sv/sltt_front.sv */
// Front end: accepts requests, classifies them and queues them for the engine.
`default_nettype none
module sltt_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sltt_pkg::req_type req_data,
   output logic              q_valid,
   output sltt_pkg::item_type q_item,
   input  logic              q_pop
);
   import sltt_pkg::*;

   item_type   slot_ff [2];
   item_type   item_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push, pop;

   // Classify: unknown kind runs as a poll, scale durations to microseconds
   always_comb begin
      item_in.kind      = (req_data.kind == KIND_ADD || req_data.kind == KIND_STOP) ?
                          req_data.kind : KIND_POLL;
      item_in.now_us    = req_data.now_us;
      item_in.peer      = req_data.peer_addr;
      item_in.id        = req_data.sub_id;
      item_in.action    = req_data.req_action;
      item_in.period_ms = req_data.period_ms;
      item_in.dur_us    = 36'(req_data.duration_s) * 36'(US_PER_S);
      item_in.per_us    = 26'(req_data.period_ms) * 26'(US_PER_MS);
   end

   assign req_stall = (fill_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign pop       = q_pop && (fill_ff != 2'd0);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = slot_ff[rd_ptr_ff];

   // Queue pointers
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= item_in;
      end
   end

endmodule
`default_nettype wire

/* sv/sltt_back.sv */
// Back end: lease table, self timer and the sequencer that walks the table.
`default_nettype none
module sltt_back #(
   parameter int MAX_LEASES = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [63:0]          csr_wdata,
   input  logic                 q_valid,
   input  sltt_pkg::item_type   q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sltt_pkg::rsp_type    rsp_data,
   output sltt_pkg::status_type status
);
   import sltt_pkg::*;

   localparam int CW = $clog2(MAX_LEASES + 1);
   localparam int IW = (MAX_LEASES > 1) ? $clog2(MAX_LEASES) : 1;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SELF  = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;
   localparam logic [1:0] ST_FINAL = 2'd3;

   lease_type   tbl_ff [MAX_LEASES];
   item_type    cur_ff, cur_in;
   logic [1:0]  st_ff, st_in;
   logic [CW-1:0] cnt_ff, cnt_in, i_ff, i_in, w_ff, w_in;
   logic [63:0] period_ff, period_in, self_due_ff, self_due_in;
   logic        rearm_ff, rearm_in;
   logic        ov_ff, ov_in;
   rsp_type     od_ff, od_in;

   lease_type   e, wr_e;
   logic        wr_en;
   logic [IW-1:0] wr_idx;
   logic        can_emit, emit, match, expired, due;
   logic [63:0] arm_due;

   assign e        = tbl_ff[i_ff[IW-1:0]];
   assign can_emit = !ov_ff || !rsp_stall;
   assign match    = (e.peer == cur_ff.peer) && (e.id == cur_ff.id);
   assign expired  = cur_ff.now_us >= e.end_us;
   assign due      = e.due_us <= cur_ff.now_us;
   assign arm_due  = (period_ff != 64'd0) ? q_item.now_us + period_ff : '1;

   // Sequencer
   always_comb begin
      st_in       = st_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      i_in        = i_ff;
      w_in        = w_ff;
      period_in   = period_ff;
      self_due_in = self_due_ff;
      rearm_in    = rearm_ff;
      q_pop       = 1'b0;
      emit        = 1'b0;
      od_in       = od_ff;
      wr_en       = 1'b0;
      wr_idx      = w_ff[IW-1:0];
      wr_e        = e;
      unique case (st_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cur_in = q_item;
               i_in   = '0;
               w_in   = '0;
               if (rearm_ff) begin
                  self_due_in = arm_due;
                  rearm_in    = 1'b0;
               end
               st_in = (q_item.kind == KIND_POLL) ? ST_SELF : ST_WALK;
            end
         end
         ST_SELF: begin
            if (cur_ff.now_us > self_due_ff) begin
               if (can_emit) begin
                  emit        = 1'b1;
                  od_in       = '{EV_SELF, 32'd0, 32'd0, 16'd0, 1'b0};
                  self_due_in = self_due_ff + period_ff;
                  st_in       = ST_WALK;
               end
            end else begin
               st_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (i_ff == cnt_ff) begin
               if (cur_ff.kind != KIND_ADD) begin
                  cnt_in = w_ff;
               end
               st_in = ST_FINAL;
            end else if (cur_ff.kind == KIND_ADD) begin
               if (!match) begin
                  i_in = i_ff + 1'b1;
               end else if (can_emit) begin
                  emit        = 1'b1;
                  od_in       = '{EV_REFRESHED, e.peer, e.id, e.action, 1'b1};
                  wr_en       = 1'b1;
                  wr_idx      = i_ff[IW-1:0];
                  wr_e.end_us = cur_ff.now_us + 64'(cur_ff.dur_us);
                  st_in       = ST_IDLE;
               end
            end else if (cur_ff.kind == KIND_STOP) begin
               i_in = i_ff + 1'b1;
               if (!match) begin
                  wr_en = 1'b1;
                  w_in  = w_ff + 1'b1;
               end
            end else begin
               if (expired) begin
                  i_in = i_ff + 1'b1;
               end else if (!due || can_emit) begin
                  wr_en = 1'b1;
                  if (due) begin
                     emit        = 1'b1;
                     od_in       = '{EV_DUE, e.peer, e.id, e.action, 1'b0};
                     wr_e.due_us = e.due_us + 64'(e.period_ms) * 64'(US_PER_MS);
                  end
                  i_in = i_ff + 1'b1;
                  w_in = w_ff + 1'b1;
               end
            end
         end
         ST_FINAL: begin
            if (can_emit) begin
               emit  = 1'b1;
               st_in = ST_IDLE;
               unique case (cur_ff.kind)
                  KIND_ADD: begin
                     if (cnt_ff >= CW'(MAX_LEASES)) begin
                        od_in = '{EV_FULL, cur_ff.peer, cur_ff.id, cur_ff.action, 1'b1};
                     end else begin
                        od_in          = '{EV_INSERTED, cur_ff.peer, cur_ff.id,
                                           cur_ff.action, 1'b1};
                        wr_en          = 1'b1;
                        wr_idx         = cnt_ff[IW-1:0];
                        wr_e.peer      = cur_ff.peer;
                        wr_e.id        = cur_ff.id;
                        wr_e.action    = cur_ff.action;
                        wr_e.period_ms = cur_ff.period_ms;
                        wr_e.end_us    = cur_ff.now_us + 64'(cur_ff.dur_us);
                        wr_e.due_us    = (cur_ff.period_ms != 16'd0) ?
                                         cur_ff.now_us + 64'(cur_ff.per_us) - 64'd1 : '1;
                        cnt_in         = cnt_ff + 1'b1;
                     end
                  end
                  KIND_STOP: od_in = '{EV_STOPPED, cur_ff.peer, cur_ff.id, 16'd0, 1'b1};
                  default:   od_in = '{EV_POLL_DONE, 32'd0, 32'd0, 16'd0, 1'b1};
               endcase
            end
         end
         default: st_in = ST_IDLE;
      endcase
      // Register write arms the self timer on the next request
      if (csr_write) begin
         period_in = csr_wdata;
         rearm_in  = 1'b1;
      end
      ov_in = emit ? 1'b1 : (ov_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_IDLE;
         cnt_ff      <= '0;
         i_ff        <= '0;
         w_ff        <= '0;
         period_ff   <= 64'd0;
         self_due_ff <= '1;
         rearm_ff    <= 1'b1;
         ov_ff       <= 1'b0;
      end else begin
         st_ff       <= st_in;
         cnt_ff      <= cnt_in;
         i_ff        <= i_in;
         w_ff        <= w_in;
         period_ff   <= period_in;
         self_due_ff <= self_due_in;
         rearm_ff    <= rearm_in;
         ov_ff       <= ov_in;
      end
   end

   // Payload registers and table write port
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      od_ff  <= od_in;
      if (wr_en) begin
         tbl_ff[wr_idx] <= wr_e;
      end
   end

   assign rsp_valid    = ov_ff;
   assign rsp_data     = od_ff;
   assign status.count = CNT_W'(cnt_ff);
   assign status.idle  = (st_ff == ST_IDLE);

endmodule
`default_nettype wire

/* sv/subscription_lease_timer_table_core.sv */
// Top level of the subscription lease timer table.
// Requests enter on req_valid/req_stall/req_data; each carries the current time
// and is an add/refresh, a stop or a poll (an unknown kind runs as a poll).
// Results leave on rsp_valid/rsp_stall/rsp_data; rsp_data.last marks the final
// result of a request. The csr_write/csr_wdata port loads the self timer period,
// which is armed from the time of the next request.
// A two-entry queue sits behind the input, so requests are taken while the
// engine works. An add walks the table up to its match or, with no match,
// to the end; a stop and a poll walk the whole table. The engine reads one
// table entry per cycle unless a result it must emit waits on rsp_stall.
// Results go through one output register; while rsp_stall is high the engine
// holds its place in the table walk and the queue fills, then req_stall rises.
// Reset (synchronous) empties the table and the queue, stops the self timer
// and clears the period; table contents need no clearing.
`default_nettype none
module subscription_lease_timer_table_core #(
   parameter int MAX_LEASES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sltt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sltt_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [63:0]       csr_wdata
);
   import sltt_pkg::*;

   logic       q_valid, q_pop;
   item_type   q_item;
   status_type status;

   sltt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop)
   );

   sltt_back #(.MAX_LEASES(MAX_LEASES)) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .status    (status)
   );

`ifndef SYNTHESIS
   // Table never overfills
   a_cnt_max: assert property (@(posedge clock) disable iff (reset)
      status.count <= CNT_W'(MAX_LEASES))
      else $error("lease count above table size");

   // Table grows by at most one entry per cycle
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> status.count <= $past(status.count) + 1'b1)
      else $error("lease count jumped");

   // An idle engine with a full output has just finished a request
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      status.idle && $rose(rsp_valid) |-> rsp_data.last)
      else $error("engine idle before final result");
`endif

endmodule
`default_nettype wire

/* verif/tb.sv */
// Testbench for the subscription lease timer table: random requests, stalls and a scoreboard.
`default_nettype none
module tb;
   import sltt_pkg::*;

   localparam int NLEASE = 16;
   localparam logic [63:0] NEVER_US = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam int LIMIT_CYCLES = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [63:0] csr_wdata = '0;

   subscription_lease_timer_table_core #(.MAX_LEASES(NLEASE)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   // predictor copy of the lease table
   lease_type leases[NLEASE];
   int unsigned lease_cnt;
   logic [63:0] self_due_us;
   logic [63:0] self_per_us;
   logic self_arm;

   req_type pending_reqs[$];
   rsp_type expected_rsps[$];
   int errors = 0;
   int cycles = 0;
   int rsp_seen = 0;
   int due_seen = 0;
   int self_seen = 0;
   int full_seen = 0;
   bit long_hold = 1'b0;
   bit quiet_sender = 1'b0;

   // clock
   initial begin
      forever #1 clock = ~clock;
   end

   task automatic push_rsp(logic [2:0] ev, logic [31:0] p, logic [31:0] id, logic [15:0] a);
      rsp_type r;
      r.event_res = ev;
      r.out_peer = p;
      r.out_sub_id = id;
      r.out_action = a;
      r.last = 1'b0;
      expected_rsps.push_back(r);
   endtask

   // compute the results of one accepted request and update the table
   task automatic predict_lease_table(req_type q);
      int unsigned w;
      bit hit;
      lease_type e;
      hit = 1'b0;
      if (self_arm) begin
         self_due_us = (self_per_us != 0) ? q.now_us + self_per_us : NEVER_US;
         self_arm = 1'b0;
      end
      if (q.kind == KIND_ADD) begin
         for (int i = 0; i < lease_cnt; i++) begin
            if (!hit && leases[i].id == q.sub_id && leases[i].peer == q.peer_addr) begin
               leases[i].end_us = q.now_us + 64'(q.duration_s) * 64'(US_PER_S);
               push_rsp(EV_REFRESHED, leases[i].peer, leases[i].id, leases[i].action);
               hit = 1'b1;
            end
         end
         if (!hit) begin
            if (lease_cnt >= NLEASE) begin
               push_rsp(EV_FULL, q.peer_addr, q.sub_id, q.req_action);
            end else begin
               e.peer = q.peer_addr;
               e.id = q.sub_id;
               e.action = q.req_action;
               e.period_ms = q.period_ms;
               e.end_us = q.now_us + 64'(q.duration_s) * 64'(US_PER_S);
               e.due_us = (q.period_ms != 0) ?
                  q.now_us + 64'(q.period_ms) * 64'(US_PER_MS) - 64'd1 : NEVER_US;
               leases[lease_cnt] = e;
               lease_cnt++;
               push_rsp(EV_INSERTED, q.peer_addr, q.sub_id, q.req_action);
            end
         end
      end else if (q.kind == KIND_STOP) begin
         w = 0;
         for (int i = 0; i < lease_cnt; i++) begin
            if (!(leases[i].id == q.sub_id && leases[i].peer == q.peer_addr)) begin
               leases[w] = leases[i];
               w++;
            end
         end
         lease_cnt = w;
         push_rsp(EV_STOPPED, q.peer_addr, q.sub_id, 16'd0);
      end else begin
         // poll, and the unused kind code behaves the same
         if (q.now_us > self_due_us) begin
            push_rsp(EV_SELF, '0, '0, '0);
            self_due_us = self_due_us + self_per_us;
         end
         w = 0;
         for (int i = 0; i < lease_cnt; i++) begin
            if (q.now_us < leases[i].end_us) begin
               if (leases[i].due_us <= q.now_us) begin
                  leases[i].due_us = leases[i].due_us + 64'(leases[i].period_ms) * 64'(US_PER_MS);
                  push_rsp(EV_DUE, leases[i].peer, leases[i].id, leases[i].action);
               end
               leases[w] = leases[i];
               w++;
            end
         end
         lease_cnt = w;
         push_rsp(EV_POLL_DONE, '0, '0, '0);
      end
      expected_rsps[$].last = 1'b1;
   endtask

   // sampled handshake state, taken at the rising edge
   logic req_stall_s = 1'b0;
   always @(posedge clock) begin
      req_stall_s <= req_stall;
      if (!reset && req_valid && !req_stall) begin
         predict_lease_table(req_data);
      end
   end

   // driver: bursts and gaps, payload held while stalled
   int gap_left = 0;
   int burst_left = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_s) begin
            void'(pending_reqs.pop_front());
         end
         if (req_valid && req_stall_s) begin
            // hold request
         end else if (quiet_sender || pending_reqs.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            req_valid <= 1'b0;
         end else begin
            req_valid <= 1'b1;
            req_data <= pending_reqs[0];
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 12);
            end
            burst_left = burst_left - 1;
            if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
               gap_left = $urandom_range(1, 25);
            end
         end
      end
   end

   // receiver stall pattern
   int stall_phase = 0;
   always @(negedge clock) begin
      stall_phase = stall_phase + 1;
      if (long_hold) begin
         rsp_stall <= 1'b1;
      end else if ((stall_phase / 64) % 3 == 0) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < 40);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type x;
      cycles <= cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen <= rsp_seen + 1;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_data);
            errors <= errors + 1;
         end else begin
            x = expected_rsps.pop_front();
            if (x.event_res == EV_DUE) due_seen <= due_seen + 1;
            if (x.event_res == EV_SELF) self_seen <= self_seen + 1;
            if (x.event_res == EV_FULL) full_seen <= full_seen + 1;
            if (rsp_data.event_res !== x.event_res || rsp_data.out_peer !== x.out_peer ||
                rsp_data.out_sub_id !== x.out_sub_id || rsp_data.out_action !== x.out_action ||
                rsp_data.last !== x.last) begin
               $display("%0t: result mismatch, expected %p, actual %p", $time, x, rsp_data);
               errors <= errors + 1;
            end
         end
      end
   end

   // timeout
   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycles);
         $display("DONE: errors detected");
         $finish;
      end
   end

   logic [63:0] clock_us = 64'd1000;
   logic [31:0] peer_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0F0F};

   function automatic req_type make_req(logic [1:0] k, logic [63:0] t, logic [31:0] p,
                                        logic [31:0] id, logic [15:0] d, logic [15:0] per,
                                        logic [15:0] a);
      req_type q;
      q.kind = k;
      q.now_us = t;
      q.peer_addr = p;
      q.sub_id = id;
      q.duration_s = d;
      q.period_ms = per;
      q.req_action = a;
      return q;
   endfunction

   // random request: mostly small peer/id pool and advancing time
   function automatic req_type rand_req();
      logic [1:0] k;
      int r;
      r = $urandom_range(0, 99);
      k = (r < 45) ? KIND_ADD : (r < 60) ? KIND_STOP : (r < 97) ? KIND_POLL : 2'd3;
      clock_us = clock_us + 64'($urandom_range(0, 3000000));
      if ($urandom_range(0, 49) == 0) clock_us = {$urandom, $urandom};
      return make_req(k, clock_us,
         ($urandom_range(0, 9) == 0) ? $urandom : peer_pool[$urandom_range(0, 3)],
         ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 5)),
         ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)),
         ($urandom_range(0, 4) == 0) ? 16'($urandom) :
            ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 1500)),
         16'($urandom));
   endfunction

   task automatic wait_drained();
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_period(logic [63:0] v);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_write <= 1'b0;
      self_per_us = v;
      self_arm = 1'b1;
   endtask

   initial begin
      lease_cnt = 0;
      self_due_us = NEVER_US;
      self_per_us = '0;
      self_arm = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, fill the table, every kind
      write_period(64'd500);
      pending_reqs.push_back(make_req(KIND_ADD, 64'd0, 32'h0, 32'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      pending_reqs.push_back(make_req(KIND_ADD, 64'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd0,
                                      16'd0, 16'h0));
      pending_reqs.push_back(make_req(KIND_ADD, 64'd20, 32'h0, 32'h0, 16'd5, 16'd1, 16'h1));
      for (int i = 0; i < 15; i++) begin
         pending_reqs.push_back(make_req(KIND_ADD, 64'd30, 32'h77, 32'(i), 16'd2, 16'd1, 16'(i)));
      end
      pending_reqs.push_back(make_req(KIND_POLL, 64'd1000, '0, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(2'd3, 64'd2000, '0, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(KIND_STOP, 64'd2100, 32'h77, 32'd3, '0, '0, '0));
      pending_reqs.push_back(make_req(KIND_STOP, 64'd2200, 32'h99, 32'd3, '0, '0, '0));
      pending_reqs.push_back(make_req(KIND_POLL, 64'd3_000_000, '0, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(KIND_POLL, NEVER_US, '0, '0, '0, '0, '0));
      wait_drained();

      // random phases under several self timer periods
      write_period(NEVER_US);
      for (int i = 0; i < 60; i++) pending_reqs.push_back(rand_req());
      // long receiver hold-off while requests keep coming
      long_hold = 1'b1;
      repeat (300) @(posedge clock);
      long_hold = 1'b0;
      wait_drained();

      write_period(64'd0);
      for (int i = 0; i < 70; i++) pending_reqs.push_back(rand_req());
      wait_drained();

      write_period(64'd700_000);
      for (int i = 0; i < 80; i++) pending_reqs.push_back(rand_req());
      // sender pause until all results are in
      while (pending_reqs.size() > 40) @(posedge clock);
      quiet_sender = 1'b1;
      while (expected_rsps.size() != 0 || req_valid) @(posedge clock);
      quiet_sender = 1'b0;
      wait_drained();

      $display("covered %0d results: %0d periodic, %0d self timer, %0d table full",
               rsp_seen, due_seen, self_seen, full_seen);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
`default_nettype wire
